// ----- design/lf4_pkg.sv -----
// Shared types and constants of the four-stage Laguerre filter.
package lf4_pkg;

  localparam int PRICE_W    = 32;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int GAMMA_W    = 17;
  localparam int GAMMA_FRAC = 16;
  localparam logic [GAMMA_W-1:0] GAMMA_ONE = 17'h10000;
  localparam logic [GAMMA_W-1:0] GAMMA_RST = 17'h08000;

  // Register select: paddr bit 2 picks the register slot.
  localparam logic REG_GAMMA = 1'b0;

  // Shared multiplier: gamma by a 32-bit slice of the magnitude.
  localparam int MUL_W  = 32;
  localparam int PROD_W = GAMMA_W + MUL_W;

  // Division of the rounded sum by three, several quotient bits per cycle.
  localparam int DIV_W      = 35;
  localparam int DIV_STEP   = 7;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = 3;

  localparam int STAGE_N     = 4;
  localparam int STAGE_IDX_W = 2;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_LOAD = 11'b000_0000_0010,
    ST_DIFF = 11'b000_0000_0100,
    ST_MLO  = 11'b000_0000_1000,
    ST_MHI  = 11'b000_0001_0000,
    ST_RND  = 11'b000_0010_0000,
    ST_UPD  = 11'b000_0100_0000,
    ST_FIN  = 11'b000_1000_0000,
    ST_PREP = 11'b001_0000_0000,
    ST_DIV  = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic                   accept;
    logic                   load;
    logic                   diff;
    logic                   mul_lo;
    logic                   mul_hi;
    logic                   rnd;
    logic                   upd;
    logic                   fin;
    logic                   prep;
    logic                   div;
    logic                   done;
    logic [STAGE_IDX_W-1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic med_zero;
    logic out_busy;
  } sts_t;

endpackage

// ----- design/lf4_ctrl.sv -----
// Sequencer of the Laguerre filter: walks each item through the datapath steps.
module lf4_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lf4_pkg::sts_t sts_i,
  output lf4_pkg::cmd_t cmd_o
);
  import lf4_pkg::*;

  state_e                 state_q, state_d;
  logic [STAGE_IDX_W-1:0] stage_q, stage_d;
  logic [DIV_CNT_W-1:0]   dcnt_q, dcnt_d;

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    dcnt_d  = dcnt_q;
    cmd_o   = '0;
    cmd_o.stage = stage_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        stage_d    = '0;
        state_d    = sts_i.med_zero ? ST_DONE : ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        if (stage_q == STAGE_IDX_W'(STAGE_N - 1)) begin
          state_d = ST_FIN;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = ST_DIFF;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        dcnt_d     = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        dcnt_d    = dcnt_q + 1'b1;
        if (dcnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the item over once the output register is free.
        if (!sts_i.out_busy) begin
          cmd_o.done = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

// ----- design/lf4_dpath.sv -----
// Datapath of the Laguerre filter: stage registers, shared multiplier, divider and output.
module lf4_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lf4_pkg::cmd_t                 cmd_i,
  output lf4_pkg::sts_t                 sts_o,
  input  logic [lf4_pkg::GAMMA_W-1:0]   gamma_i,
  input  logic [lf4_pkg::PRICE_W-1:0]   price_high_i,
  input  logic [lf4_pkg::PRICE_W-1:0]   price_low_i,
  input  logic                          run_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lf4_pkg::PRICE_W-1:0]   filtered_o,
  output logic                          valid_res_o
);
  import lf4_pkg::*;

  localparam int STAGE_W = 34 + FRAC_BITS;
  localparam int PHI_W   = GAMMA_W + STAGE_W - MUL_W;
  localparam int FULL_W  = STAGE_W + GAMMA_W + 1;
  localparam int NEW_W   = STAGE_W + 2;
  localparam int SUM_W   = STAGE_W + 3;
  localparam int MED_W   = PRICE_W + 1;

  localparam logic [STAGE_W-1:0] STAGE_MAX = {1'b0, {(STAGE_W-1){1'b1}}};
  localparam logic [STAGE_W-1:0] STAGE_MIN = {1'b1, {(STAGE_W-1){1'b0}}};
  localparam logic [FULL_W-1:0]  RND_HALF  = FULL_W'(1) << (GAMMA_FRAC - 1);
  localparam logic [SUM_W-1:0]   SUM_BIAS  = SUM_W'(3) << FRAC_BITS;

  logic [STAGE_W-1:0] stage_q [STAGE_N];
  logic               seeded_q;
  logic [STAGE_W-1:0] price_q;
  logic               med_zero_q;
  logic [STAGE_W-1:0] base_q;
  logic [STAGE_W-1:0] up_q;
  logic               neg_q;
  logic [STAGE_W-1:0] mag_q;
  logic [PROD_W-1:0]  plo_q;
  logic [PHI_W-1:0]   phi_q;
  logic [STAGE_W:0]   r_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DIV_W-1:0]   z_q;
  logic [DIV_W-1:0]   quo_q;
  logic [1:0]         rem_q;
  logic               vres_q;
  logic               out_valid_q;
  logic [PRICE_W-1:0] filtered_q;
  logic               valid_res_q;

  logic [MED_W-1:0]   med_sum;
  logic [STAGE_W:0]   diff;
  logic [STAGE_W-1:0] cur;
  logic [MUL_W-1:0]   mop;
  logic [PROD_W-1:0]  prod;
  logic [FULL_W-1:0]  full;
  logic [NEW_W-1:0]   base_ext;
  logic [NEW_W-1:0]   r_ext;
  logic [NEW_W-1:0]   nv;
  logic [STAGE_W-1:0] nv_sat;
  logic [SUM_W-1:0]   up_ext;
  logic [SUM_W-1:0]   sum_bias;
  logic               sum_pos;
  logic [DIV_W-1:0]   z_nx;
  logic [DIV_W-1:0]   quo_nx;
  logic [1:0]         rem_nx;
  logic [2:0]         rem3;

  assign med_sum = {1'b0, price_high_i} + {1'b0, price_low_i};
  assign cur     = stage_q[cmd_i.stage];
  assign diff    = {cur[STAGE_W-1], cur} - {up_q[STAGE_W-1], up_q};

  // One gamma multiplier serves both halves of the magnitude.
  assign mop  = cmd_i.mul_hi ? MUL_W'(mag_q[STAGE_W-1:MUL_W]) : mag_q[MUL_W-1:0];
  assign prod = PROD_W'(gamma_i) * PROD_W'(mop);

  // Round-to-nearest of gamma * magnitude, ties away from zero via the magnitude.
  assign full = (FULL_W'(phi_q) << MUL_W) + FULL_W'(plo_q) + RND_HALF;

  assign base_ext = {{2{base_q[STAGE_W-1]}}, base_q};
  assign r_ext    = {1'b0, r_q};
  assign nv       = neg_q ? (base_ext - r_ext) : (base_ext + r_ext);

  always_comb begin
    if (nv[NEW_W-1:STAGE_W-1] == '0 || nv[NEW_W-1:STAGE_W-1] == '1) begin
      nv_sat = nv[STAGE_W-1:0];
    end else if (nv[NEW_W-1]) begin
      nv_sat = STAGE_MIN;
    end else begin
      nv_sat = STAGE_MAX;
    end
  end

  assign up_ext   = {{3{up_q[STAGE_W-1]}}, up_q};
  assign sum_bias = sum_q + SUM_BIAS;
  assign sum_pos  = !sum_q[SUM_W-1] && (sum_q != '0);

  // Long division by three, a few quotient bits per cycle.
  always_comb begin
    z_nx   = z_q;
    quo_nx = quo_q;
    rem_nx = rem_q;
    rem3   = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      rem3 = {rem_nx, z_nx[DIV_W-1]};
      z_nx = {z_nx[DIV_W-2:0], 1'b0};
      if (rem3 >= 3'd3) begin
        rem3   = rem3 - 3'd3;
        quo_nx = {quo_nx[DIV_W-2:0], 1'b1};
      end else begin
        quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
      end
      rem_nx = rem3[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGE_N; i++) begin
        stage_q[i] <= '0;
      end
      seeded_q <= 1'b0;
    end else begin
      if (cmd_i.accept && run_start_i) begin
        seeded_q <= 1'b0;
      end
      if (cmd_i.load && !med_zero_q && !seeded_q) begin
        for (int i = 0; i < STAGE_N; i++) begin
          stage_q[i] <= price_q;
        end
        seeded_q <= 1'b1;
      end
      if (cmd_i.upd) begin
        stage_q[cmd_i.stage] <= nv_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      price_q    <= STAGE_W'(med_sum) << (FRAC_BITS - 1);
      med_zero_q <= (med_sum == '0);
    end
    if (cmd_i.load) begin
      base_q <= price_q;
      up_q   <= price_q;
      sum_q  <= '0;
      z_q    <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      vres_q <= !med_zero_q;
    end
    if (cmd_i.diff) begin
      neg_q <= diff[STAGE_W];
      mag_q <= diff[STAGE_W] ? STAGE_W'(-diff) : diff[STAGE_W-1:0];
      // The previous stage's new value enters the weighted sum here.
      if (cmd_i.stage == STAGE_IDX_W'(1)) begin
        sum_q <= sum_q + up_ext;
      end else if (cmd_i.stage != '0) begin
        sum_q <= sum_q + (up_ext << 1);
      end
    end
    if (cmd_i.mul_lo) begin
      plo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      phi_q <= prod[PHI_W-1:0];
    end
    if (cmd_i.rnd) begin
      r_q <= full[STAGE_W+GAMMA_FRAC:GAMMA_FRAC];
    end
    if (cmd_i.upd) begin
      base_q <= cur;
      up_q   <= nv_sat;
    end
    if (cmd_i.fin) begin
      sum_q <= sum_q + up_ext;
    end
    if (cmd_i.prep) begin
      z_q <= sum_pos ? sum_bias[FRAC_BITS+DIV_W:FRAC_BITS+1] : '0;
    end
    if (cmd_i.div) begin
      z_q   <= z_nx;
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
    if (cmd_i.done) begin
      filtered_q  <= (quo_q[DIV_W-1:PRICE_W] != '0) ? '1 : quo_q[PRICE_W-1:0];
      valid_res_q <= vres_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.med_zero = med_zero_q;
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign filtered_o     = filtered_q;
  assign valid_res_o    = valid_res_q;

endmodule

// ----- design/laguerre_filter_four_stage_unit.sv -----
// Top level of the four-stage Laguerre filter: register port, sequencer and datapath.
// Each item (one bar) is loaded, then the four stages run one after another through a
// single 17x32 gamma multiplier (difference, two partial products, rounding, update),
// the weighted sum is completed, the divide by three retires seven quotient bits a
// cycle, and the item is handed over. A bar whose high and low are both zero goes from
// loading straight to hand-over with valid_res low. The result sits in an output
// register, so the next item is accepted while the previous result still waits. Gamma
// is written over the APB port at address 0; the user must write it only while the
// block is idle, which the block itself does not enforce; values above 1.0 act as 1.0.
module laguerre_filter_four_stage_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lf4_pkg::ADDR_W-1:0]    paddr,
  input  logic [lf4_pkg::DATA_W-1:0]    pwdata,
  output logic [lf4_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lf4_pkg::PRICE_W-1:0]   price_high_i,
  input  logic [lf4_pkg::PRICE_W-1:0]   price_low_i,
  input  logic                          run_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lf4_pkg::PRICE_W-1:0]   filtered_o,
  output logic                          valid_res_o
);
  import lf4_pkg::*;

  logic [GAMMA_W-1:0] gamma_q;
  logic [GAMMA_W-1:0] gamma_eff;
  logic               cfg_wr;
  cmd_t               cmd;
  sts_t               sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GAMMA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RST;
    end else if (cfg_wr) begin
      gamma_q <= pwdata[GAMMA_W-1:0];
    end
  end

  assign prdata    = (paddr[2] == REG_GAMMA) ? DATA_W'(gamma_q) : '0;
  assign gamma_eff = (gamma_q > GAMMA_ONE) ? GAMMA_ONE : gamma_q;

  lf4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lf4_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .gamma_i      (gamma_eff),
    .price_high_i (price_high_i),
    .price_low_i  (price_low_i),
    .run_start_i  (run_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filtered_o   (filtered_o),
    .valid_res_o  (valid_res_o)
  );

endmodule

// ----- design/lf4_checker.sv -----
// Port-level checks of the Laguerre filter and their attachment to the top level.
module lf4_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lf4_pkg::PRICE_W-1:0] filtered_o,
  input logic                        valid_res_o,
  input logic                        pready
);

  // An accepted item keeps the input side closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an item was accepted");

  // A result that did not advance the filter carries a zero price.
  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (filtered_o == '0))
    else $error("non-advancing result with a nonzero price");

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(filtered_o) && $stable(valid_res_o)))
    else $error("stalled result changed or vanished");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("register port not ready");

endmodule

bind laguerre_filter_four_stage_unit lf4_checker u_lf4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .filtered_o  (filtered_o),
  .valid_res_o (valid_res_o),
  .pready      (pready)
);
